// ===== rtl/core/lps_pkg.sv =====
`timescale 1ns / 1ps

package lps_pkg;

  localparam int DimW   = 12;
  localparam int CoordW = 16;
  localparam int ColorW = 32;
  localparam int IndexW = 22;
  localparam int PosW   = 29;
  localparam int StepW  = 18;
  localparam int CountW = 13;
  localparam int RootW  = 24;
  localparam int RadW   = 2 * RootW;
  localparam int QuotW  = 17;

  localparam logic [4:0] RootIters = 5'd24;
  localparam logic [4:0] DivIters  = 5'd17;

  typedef enum logic [1:0] {
    KIND_STEP,
    KIND_START,
    KIND_DROP
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LOAD,
    ST_ROOT,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
    logic [CoordW-2:0]        sx;
    logic [CoordW-2:0]        sy;
    logic [ColorW-1:0]        color;
  } entry_t;

endpackage

// ===== rtl/core/line_pixel_stepper.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_stall    in_op, in_start_x/y, in_end_x/y, in_pen_color
// out       out_valid / out_stall  out_pixel_index, out_pixel_value, out_last
// cfg       psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// A pixel step is done in the back end; steps can stream at one per cycle while the output is not stalled.
// A line start goes through take, squares, load, 24 root and 17 divide iterations;
// a line shorter than one pixel skips the divide.
// Dropped starts and steps past the end are popped and give no transfer.
// A two-entry queue sits between front and back; in_stall rises when it is full.
// Reset clears the queue, state and output valid; frame size resets to 640 x 480.

module line_pixel_stepper #(
  parameter int MAX_FRAME_DIM = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic signed [lps_pkg::CoordW-1:0]  in_start_x,
  input  logic signed [lps_pkg::CoordW-1:0]  in_start_y,
  input  logic signed [lps_pkg::CoordW-1:0]  in_end_x,
  input  logic signed [lps_pkg::CoordW-1:0]  in_end_y,
  input  logic [lps_pkg::ColorW-1:0]         in_pen_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lps_pkg::IndexW-1:0]         out_pixel_index,
  output logic [lps_pkg::ColorW-1:0]         out_pixel_value,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import lps_pkg::*;

  localparam logic [DimW:0] MaxDim = (DimW+1)'(MAX_FRAME_DIM);

  logic [DimW-1:0] frame_width_r;
  logic [DimW-1:0] frame_height_r;
  logic [DimW-1:0] eff_width;
  logic [DimW-1:0] eff_height;
  logic            cfg_write;
  entry_t          push_entry;
  entry_t          head;
  logic            head_valid;
  logic            pop;
  logic            full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[2] ? {20'b0, frame_height_r} : {20'b0, frame_width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DimW'(640);
      frame_height_r <= DimW'(480);
    end else if (cfg_write) begin
      if (paddr[2]) begin
        frame_height_r <= pwdata[DimW-1:0];
      end else begin
        frame_width_r <= pwdata[DimW-1:0];
      end
    end
  end

  assign eff_width  = ({1'b0, frame_width_r} > MaxDim) ? MaxDim[DimW-1:0] : frame_width_r;
  assign eff_height = ({1'b0, frame_height_r} > MaxDim) ? MaxDim[DimW-1:0] : frame_height_r;

  assign in_stall = full;

  lps_front u_front (
    .op        (in_op),
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .end_x     (in_end_x),
    .end_y     (in_end_y),
    .pen_color (in_pen_color),
    .width     (eff_width),
    .height    (eff_height),
    .entry     (push_entry)
  );

  lps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_data  (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  lps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .width           (eff_width),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value),
    .out_last        (out_last)
  );

endmodule

// ===== rtl/core/lps_front.sv =====
`timescale 1ns / 1ps

module lps_front (
  input  logic                             op,
  input  logic signed [lps_pkg::CoordW-1:0] start_x,
  input  logic signed [lps_pkg::CoordW-1:0] start_y,
  input  logic signed [lps_pkg::CoordW-1:0] end_x,
  input  logic signed [lps_pkg::CoordW-1:0] end_y,
  input  logic [lps_pkg::ColorW-1:0]        pen_color,
  input  logic [lps_pkg::DimW-1:0]          width,
  input  logic [lps_pkg::DimW-1:0]          height,
  output lps_pkg::entry_t                   entry
);
  import lps_pkg::*;

  logic [CoordW-1:0] w_lim;
  logic [CoordW-1:0] h_lim;
  logic              neg;
  logic              over;

  assign w_lim = {width, 4'b0};
  assign h_lim = {height, 4'b0};
  assign neg   = start_x[CoordW-1] | start_y[CoordW-1] | end_x[CoordW-1] | end_y[CoordW-1];
  assign over  = ({1'b0, start_x[CoordW-2:0]} >= w_lim) | ({1'b0, end_x[CoordW-2:0]} >= w_lim) |
                 ({1'b0, start_y[CoordW-2:0]} >= h_lim) | ({1'b0, end_y[CoordW-2:0]} >= h_lim);

  always_comb begin
    entry.dx    = end_x - start_x;
    entry.dy    = end_y - start_y;
    entry.sx    = start_x[CoordW-2:0];
    entry.sy    = start_y[CoordW-2:0];
    entry.color = pen_color;
    if (op) begin
      entry.kind = KIND_STEP;
    end else if (neg || over) begin
      entry.kind = KIND_DROP;
    end else begin
      entry.kind = KIND_START;
    end
  end

endmodule

// ===== rtl/core/lps_queue.sv =====
`timescale 1ns / 1ps

module lps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lps_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output lps_pkg::entry_t head,
  output logic            head_valid
);
  import lps_pkg::*;

  localparam int Depth = 2;
  localparam int AW    = $clog2(Depth);

  entry_t         mem [Depth];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    count_r;
  logic           do_push;
  logic           do_pop;

  assign full       = (count_r == (AW+1)'(Depth));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/core/lps_back.sv =====
`timescale 1ns / 1ps

module lps_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lps_pkg::entry_t             head,
  input  logic                        head_valid,
  output logic                        pop,
  input  logic [lps_pkg::DimW-1:0]    width,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lps_pkg::IndexW-1:0]  out_pixel_index,
  output logic [lps_pkg::ColorW-1:0]  out_pixel_value,
  output logic                        out_last
);
  import lps_pkg::*;

  state_t                   state_r, state_nxt;
  logic [4:0]               cnt_r;
  logic signed [CoordW-1:0] dx_r, dy_r;
  logic [CoordW-2:0]        sx_r, sy_r;
  logic [31:0]              sqx_r, sqy_r;
  logic [RadW-1:0]          rad_r;
  logic [RootW+1:0]         rem_r;
  logic [RootW-1:0]         root_r;
  logic [RootW-1:0]         remx_r, remy_r;
  logic [QuotW-1:0]         qx_r, qy_r;
  logic [PosW-1:0]          pos_x_r, pos_y_r;
  logic [StepW-1:0]         step_x_r, step_y_r;
  logic [CountW-1:0]        steps_left_r;
  logic [ColorW-1:0]        line_color_r;
  logic                     out_valid_r;
  logic [IndexW-1:0]        out_index_r;
  logic [ColorW-1:0]        out_value_r;
  logic                     out_last_r;

  logic                     out_free;
  logic                     emit;
  logic                     take_start;
  logic                     take_drop;

  logic [31:0]              d2_sum;
  logic [RootW+3:0]         rem_sh;
  logic [RootW+3:0]         trial;
  logic                     root_ge;
  logic [RootW+1:0]         rem_nxt;
  logic [RootW-1:0]         root_nxt;
  logic                     root_done;
  logic                     div_done;
  logic [CoordW-2:0]        magx, magy;
  logic [RootW:0]           remx_sh, remy_sh;
  logic                     gex, gey;
  logic [QuotW-1:0]         qx_nxt, qy_nxt;
  logic [24:0]              row_prod;
  logic [IndexW-1:0]        index_nxt;

  assign out_free  = !out_valid_r || !out_stall;
  assign root_done = (state_r == ST_ROOT) && (cnt_r == RootIters - 5'd1);
  assign div_done  = (state_r == ST_DIVIDE) && (cnt_r == DivIters - 5'd1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid && head.kind == KIND_START) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = (root_nxt[RootW-1:12] == '0) ? ST_IDLE : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    take_start = 1'b0;
    take_drop  = 1'b0;
    if (state_r == ST_IDLE && head_valid) begin
      unique case (head.kind)
        KIND_STEP: begin
          if (steps_left_r == '0) begin
            pop = 1'b1;
          end else if (out_free) begin
            pop  = 1'b1;
            emit = 1'b1;
          end
        end
        KIND_START: begin
          pop        = 1'b1;
          take_start = 1'b1;
        end
        KIND_DROP: begin
          pop       = 1'b1;
          take_drop = 1'b1;
        end
        default: pop = 1'b1;
      endcase
    end
  end

  assign d2_sum   = sqx_r + sqy_r;
  assign rem_sh   = {rem_r, rad_r[RadW-1 -: 2]};
  assign trial    = {2'b0, root_r, 2'b01};
  assign root_ge  = (rem_sh >= trial);
  assign rem_nxt  = root_ge ? (RootW+2)'(rem_sh - trial) : rem_sh[RootW+1:0];
  assign root_nxt = {root_r[RootW-2:0], root_ge};

  assign magx = dx_r[CoordW-1] ? (CoordW-1)'(-dx_r) : dx_r[CoordW-2:0];
  assign magy = dy_r[CoordW-1] ? (CoordW-1)'(-dy_r) : dy_r[CoordW-2:0];

  assign remx_sh = {remx_r, 1'b0};
  assign remy_sh = {remy_r, 1'b0};
  assign gex     = (remx_sh >= {1'b0, root_r});
  assign gey     = (remy_sh >= {1'b0, root_r});
  assign qx_nxt  = {qx_r[QuotW-2:0], gex};
  assign qy_nxt  = {qy_r[QuotW-2:0], gey};

  assign row_prod  = {12'b0, pos_y_r[PosW-1:16]} * {13'b0, width};
  assign index_nxt = row_prod[IndexW-1:0] + {9'b0, pos_x_r[PosW-1:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      steps_left_r <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      step_x_r     <= '0;
      step_y_r     <= '0;
      line_color_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (emit) begin
        pos_x_r      <= pos_x_r + {{(PosW-StepW){step_x_r[StepW-1]}}, step_x_r};
        pos_y_r      <= pos_y_r + {{(PosW-StepW){step_y_r[StepW-1]}}, step_y_r};
        steps_left_r <= steps_left_r - CountW'(1);
      end

      if (take_start || take_drop) begin
        line_color_r <= head.color;
        steps_left_r <= '0;
      end

      if (state_r == ST_LOAD || (root_done && root_nxt[RootW-1:12] != '0)) begin
        cnt_r <= '0;
      end else if (state_r == ST_ROOT || state_r == ST_DIVIDE) begin
        cnt_r <= cnt_r + 5'd1;
      end

      if (div_done) begin
        step_x_r     <= dx_r[CoordW-1] ? (StepW'(0) - {1'b0, qx_nxt}) : {1'b0, qx_nxt};
        step_y_r     <= dy_r[CoordW-1] ? (StepW'(0) - {1'b0, qy_nxt}) : {1'b0, qy_nxt};
        pos_x_r      <= {2'b0, sx_r, 12'b0};
        pos_y_r      <= {2'b0, sy_r, 12'b0};
        steps_left_r <= {1'b0, root_r[RootW-1:12]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_start) begin
      dx_r <= head.dx;
      dy_r <= head.dy;
      sx_r <= head.sx;
      sy_r <= head.sy;
    end
    if (state_r == ST_SQUARE) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
    end
    if (state_r == ST_LOAD) begin
      rad_r  <= {1'b0, d2_sum[30:0], 16'b0};
      rem_r  <= '0;
      root_r <= '0;
    end
    if (state_r == ST_ROOT) begin
      rad_r  <= {rad_r[RadW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      if (root_done) begin
        remx_r <= {2'b0, magx, 7'b0};
        remy_r <= {2'b0, magy, 7'b0};
        qx_r   <= '0;
        qy_r   <= '0;
      end
    end
    if (state_r == ST_DIVIDE) begin
      remx_r <= gex ? RootW'(remx_sh - {1'b0, root_r}) : remx_sh[RootW-1:0];
      remy_r <= gey ? RootW'(remy_sh - {1'b0, root_r}) : remy_sh[RootW-1:0];
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
    end
    if (emit) begin
      out_index_r <= index_nxt;
      out_value_r <= line_color_r;
      out_last_r  <= (steps_left_r == CountW'(1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_index_r;
  assign out_pixel_value = out_value_r;
  assign out_last        = out_last_r;

endmodule
